// ===== sv/numr_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Numerov recurrence block.
// Used by numr_div and numerov_recurrence_step; depends on nothing else.
`default_nettype none

package numr_pkg;

    // Grid limit of one pass and the width of the point counter that follows from it.
    localparam int MAX_POINTS = 1024;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int PT_W       = 11;

    // Serial divider: one quotient bit per cycle.
    localparam int DIV_STEPS = 32;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    localparam logic signed [31:0] PSI_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] PSI_MIN = 32'sh8000_0000;
    localparam logic signed [37:0] Q_ONE   = 38'sd65536;
    localparam logic signed [37:0] Q_TWO   = 38'sd131072;

    typedef enum logic [1:0] {
        CFG_ENERGY     = 2'd0,
        CFG_COEF_C     = 2'd1,
        CFG_PSI_FIRST  = 2'd2,
        CFG_PSI_SECOND = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_K0,
        ST_K1,
        ST_K2,
        ST_COEF,
        ST_MA,
        ST_MB,
        ST_NUM,
        ST_CHK,
        ST_DIV,
        ST_SIGN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic signed [31:0] potential_sample;
        logic               pass_end;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] psi_value;
        logic [PT_W-1:0]    point_index;
        logic               pass_last;
        logic               numeric_fault;
    } t_out_word;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } t_sat;

    // Saturate to the signed 32-bit range; overflow when the top bits disagree.
    function automatic t_sat sat32(input logic signed [37:0] v);
        t_sat r;
        r.ovf = !((&v[37:31]) || !(|v[37:31]));
        r.val = r.ovf ? (v[37] ? PSI_MIN : PSI_MAX) : v[31:0];
        return r;
    endfunction

    function automatic logic signed [32:0] diff33(input logic signed [31:0] e,
                                                  input logic signed [31:0] v);
        return $signed({e[31], e}) - $signed({v[31], v});
    endfunction

    function automatic logic [32:0] abs33(input logic signed [32:0] d);
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

    // Magnitude of a 32-bit value; the most negative value maps to 2^31.
    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // c*|E-V| >> 32 with the sign of E-V restored.
    function automatic logic signed [32:0] kterm(input logic [65:0] prod, input logic neg);
        logic [32:0] p;
        p = {1'b0, prod[63:32]};
        return neg ? $signed(-p) : $signed(p);
    endfunction

    function automatic logic signed [63:0] sgn64(input logic [65:0] prod, input logic neg);
        logic [63:0] p;
        p = prod[63:0];
        return neg ? $signed(-p) : $signed(p);
    endfunction

endpackage

`default_nettype wire

// ===== sv/numr_mul.sv =====
// Shared unsigned 33x33 multiplier with a registered product.
// Depends on nothing but the clock; magnitudes in, signs are handled by the sequencer.
`default_nettype none

module numr_mul (
    input  wire logic        i_clk,
    input  wire logic [32:0] i_op_a,
    input  wire logic [32:0] i_op_b,
    output      logic [65:0] o_prod
);

    logic [65:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 66'(i_op_a) * 66'(i_op_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== sv/numr_div.sv =====
// Restoring serial divider, one quotient bit per cycle: {rem, lo} / dvs with rem < dvs.
// Uses numr_pkg for the step count.
`default_nettype none

module numr_div import numr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_rem,
    input  wire logic [31:0] i_lo,
    input  wire logic [31:0] i_dvs,
    output      logic        o_done,
    output      logic [31:0] o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [31:0]       r_rem;
    logic [31:0]       r_lo;
    logic [31:0]       r_dvs;
    logic [32:0]       w_trial;
    logic              w_ge;

    // The remainder stays below the divisor, so the difference fits in 32 bits.
    assign w_trial = {r_rem, r_lo[31]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_lo  <= i_lo;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_rem <= w_ge ? 32'(w_trial - {1'b0, r_dvs}) : w_trial[31:0];
            r_lo  <= {r_lo[30:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_lo;

endmodule

`default_nettype wire

// ===== sv/numerov_recurrence_step.sv =====
// Numerov recurrence step: one potential sample in, one Q16.16 wavefunction word out.
// Points 0 and 1 of a pass return the configured starting values.
// From point 2 on, a sequencer runs five products through one shared multiplier and
// then a 32-step serial divider; a zero divisor or an oversized quotient skips the
// divider. The input is taken only when the sequencer is idle; a finished word waits in
// the output register while the next input word is taken, but the result of that word
// waits in the sequencer until the register is free. Uses numr_pkg, numr_mul and
// numr_div. Overflow and a zero divisor set numeric_fault and saturate the result, but
// zero over zero gives 0; numeric_fault stays set until the next pass starts.
`default_nettype none

module numerov_recurrence_step import numr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_ready,
    input  wire t_in_word    i_in_data,
    output      logic        o_out_valid,
    input  wire logic        i_out_ready,
    output      t_out_word   o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    t_state r_state;
    t_state n_state;

    logic signed [31:0] r_energy;
    logic [31:0]        r_coef;
    logic signed [31:0] r_psi_first;
    logic signed [31:0] r_psi_second;

    logic signed [31:0] r_psi_b1;
    logic signed [31:0] r_psi_b2;
    logic signed [31:0] r_pot_b1;
    logic signed [31:0] r_pot_b2;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_sticky;

    logic signed [31:0] r_pot_now;
    logic               r_end;
    logic               r_pt_flt;
    logic signed [32:0] r_k0;
    logic signed [32:0] r_k1;
    logic signed [32:0] r_k2;
    logic signed [31:0] r_a;
    logic signed [31:0] r_b;
    logic signed [31:0] r_d;
    logic signed [63:0] r_pa;
    logic signed [64:0] r_num;
    logic               r_qneg;
    logic signed [31:0] r_psi;

    logic               r_out_valid;
    t_out_word          r_out;

    logic               w_in_acc;
    logic               w_out_load;
    logic               w_last;
    logic               w_flt_next;
    logic [32:0]        w_mul_a;
    logic [32:0]        w_mul_b;
    logic [65:0]        w_prod;
    logic               w_div_start;
    logic               w_div_done;
    logic [31:0]        w_quo;

    logic signed [32:0] w_d0;
    logic signed [32:0] w_d1;
    logic signed [32:0] w_d2;
    logic signed [63:0] w_pb;
    logic [64:0]        w_num_abs;
    logic [63:0]        w_num_mag;
    logic [31:0]        w_d_mag;
    logic               w_d_zero;
    logic               w_quo_big;
    t_sat               w_sat_a;
    t_sat               w_sat_b;
    t_sat               w_sat_d;

    assign w_in_acc = i_in_valid && o_in_ready;

    // Differences E-V for the points n-2, n-1 and n.
    assign w_d0 = diff33(r_energy, r_pot_b2);
    assign w_d1 = diff33(r_energy, r_pot_b1);
    assign w_d2 = diff33(r_energy, r_pot_now);

    // A = 2(1 - 5k1) written as 2 - 8k1 - 2k1; B = 1 + k0; D = 1 + k2.
    assign w_sat_a = sat32(Q_TWO - ((38'(r_k1) <<< 3) + (38'(r_k1) <<< 1)));
    assign w_sat_b = sat32(Q_ONE + 38'(r_k0));
    assign w_sat_d = sat32(Q_ONE + 38'(r_k2));

    assign w_pb      = sgn64(w_prod, r_b[31] ^ r_psi_b2[31]);
    assign w_num_abs = r_num[64] ? 65'(-r_num) : 65'(r_num);
    assign w_num_mag = w_num_abs[63:0];
    assign w_d_mag   = abs32(r_d);
    assign w_d_zero  = (r_d == '0);
    // A quotient of 2^32 or more shows up before any division step is taken.
    assign w_quo_big = (w_num_mag[63:32] >= w_d_mag);

    assign w_last     = r_end || (r_cnt >= CNT_W'(MAX_POINTS));
    assign w_flt_next = ((r_cnt == '0) ? 1'b0 : r_sticky) | r_pt_flt;

    numr_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (w_mul_a),
        .i_op_b (w_mul_b),
        .o_prod (w_prod)
    );

    numr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_rem   (w_num_mag[63:32]),
        .i_lo    (w_num_mag[31:0]),
        .i_dvs   (w_d_mag),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (r_cnt < CNT_W'(2)) ? ST_FIN : ST_K0;
                end
            end
            ST_K0:   n_state = ST_K1;
            ST_K1:   n_state = ST_K2;
            ST_K2:   n_state = ST_COEF;
            ST_COEF: n_state = ST_MA;
            ST_MA:   n_state = ST_MB;
            ST_MB:   n_state = ST_NUM;
            ST_NUM:  n_state = ST_CHK;
            ST_CHK:  n_state = (w_d_zero || w_quo_big) ? ST_FIN : ST_DIV;
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_SIGN;
                end
            end
            ST_SIGN: n_state = ST_FIN;
            ST_FIN: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, multiplier operands, divider start.
    always_comb begin
        o_in_ready  = 1'b0;
        w_out_load  = 1'b0;
        w_div_start = 1'b0;
        w_mul_a     = {1'b0, r_coef};
        w_mul_b     = '0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_K0:   w_mul_b = abs33(w_d0);
            ST_K1:   w_mul_b = abs33(w_d1);
            ST_K2:   w_mul_b = abs33(w_d2);
            ST_MA: begin
                w_mul_a = {1'b0, abs32(r_a)};
                w_mul_b = {1'b0, abs32(r_psi_b1)};
            end
            ST_MB: begin
                w_mul_a = {1'b0, abs32(r_b)};
                w_mul_b = {1'b0, abs32(r_psi_b2)};
            end
            ST_CHK:  w_div_start = !w_d_zero && !w_quo_big;
            ST_FIN:  w_out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_energy     <= '0;
            r_coef       <= '0;
            r_psi_first  <= '0;
            r_psi_second <= 32'sd65;
            r_psi_b1     <= '0;
            r_psi_b2     <= '0;
            r_pot_b1     <= '0;
            r_pot_b2     <= '0;
            r_cnt        <= '0;
            r_sticky     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ENERGY:     r_energy     <= i_cfg_data;
                    CFG_COEF_C:     r_coef       <= i_cfg_data;
                    CFG_PSI_FIRST:  r_psi_first  <= i_cfg_data;
                    CFG_PSI_SECOND: r_psi_second <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_out_load) begin
                r_psi_b2    <= r_psi_b1;
                r_psi_b1    <= r_psi;
                r_pot_b2    <= r_pot_b1;
                r_pot_b1    <= r_pot_now;
                r_cnt       <= w_last ? '0 : r_cnt + 1'b1;
                r_sticky    <= w_flt_next;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers, stepped by the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    r_pot_now <= i_in_data.potential_sample;
                    r_end     <= i_in_data.pass_end;
                    r_pt_flt  <= 1'b0;
                    r_psi     <= (r_cnt == '0) ? r_psi_first : r_psi_second;
                end
            end
            ST_K1:   r_k0 <= kterm(w_prod, w_d0[32]);
            ST_K2:   r_k1 <= kterm(w_prod, w_d1[32]);
            ST_COEF: begin
                r_k2     <= kterm(w_prod, w_d2[32]);
                r_a      <= w_sat_a.val;
                r_b      <= w_sat_b.val;
                r_pt_flt <= r_pt_flt | w_sat_a.ovf | w_sat_b.ovf;
            end
            ST_MA: begin
                r_d      <= w_sat_d.val;
                r_pt_flt <= r_pt_flt | w_sat_d.ovf;
            end
            ST_MB:   r_pa <= sgn64(w_prod, r_a[31] ^ r_psi_b1[31]);
            ST_NUM:  r_num <= $signed({r_pa[63], r_pa}) - $signed({w_pb[63], w_pb});
            ST_CHK: begin
                r_qneg <= r_num[64] ^ r_d[31];
                if (w_d_zero) begin
                    r_pt_flt <= 1'b1;
                    if (r_num == '0) begin
                        r_psi <= '0;
                    end else begin
                        r_psi <= r_num[64] ? PSI_MIN : PSI_MAX;
                    end
                end else if (w_quo_big) begin
                    r_pt_flt <= 1'b1;
                    r_psi    <= (r_num[64] ^ r_d[31]) ? PSI_MIN : PSI_MAX;
                end
            end
            ST_SIGN: begin
                if (!r_qneg) begin
                    if (w_quo[31]) begin
                        r_psi    <= PSI_MAX;
                        r_pt_flt <= 1'b1;
                    end else begin
                        r_psi <= w_quo;
                    end
                end else if (w_quo > 32'h8000_0000) begin
                    r_psi    <= PSI_MIN;
                    r_pt_flt <= 1'b1;
                end else begin
                    r_psi <= -w_quo;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.psi_value     <= r_psi;
            r_out.point_index   <= PT_W'(r_cnt);
            r_out.pass_last     <= w_last;
            r_out.numeric_fault <= w_flt_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The divider finishes only while the sequencer waits for it.
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside its wait state");

    // The point counter never runs past the pass limit.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_POINTS))
        else $error("point counter beyond the pass limit");

    // A word that closes a pass leaves the counter at point 0.
    a_pass_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && w_last) |=> (r_cnt == '0))
        else $error("pass did not restart after its last point");

    // An item is taken only with the sequencer idle, and it never starts the divider.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> (!w_div_start && (r_state == ST_IDLE)))
        else $error("input word taken while the sequencer was busy");

endmodule

`default_nettype wire
